// File: hw/rtl/fbwpm_pkg.sv
// ----------------------------------------------------------------------------
// fbwpm_pkg
// Shared types, constants and color scaling tables of the pixel mapper.
// ----------------------------------------------------------------------------
package fbwpm_pkg;

	// Panel geometry
	localparam int PANEL_WIDTH  = 64;
	localparam int PANEL_HEIGHT = 32;

	// Field widths
	localparam int WORD_W  = 32;
	localparam int COORD_W = 12;
	localparam int CHAN_W  = 8;
	localparam int SHIFT_W = 13;
	localparam int IDX_W   = 3;
	localparam int CFG_W   = 32;

	// Signed working width of the row and column arithmetic
	localparam int POS_W = 15;

	// Register indexes of the configuration port
	localparam logic [IDX_W-1:0] REG_MODE          = 3'd0;
	localparam logic [IDX_W-1:0] REG_BITMAP_ROWS   = 3'd1;
	localparam logic [IDX_W-1:0] REG_SRC_X_WINDOW  = 3'd2;
	localparam logic [IDX_W-1:0] REG_SRC_Y_WINDOW  = 3'd3;
	localparam logic [IDX_W-1:0] REG_X_SHIFT       = 3'd4;
	localparam logic [IDX_W-1:0] REG_Y_SHIFT       = 3'd5;
	localparam logic [IDX_W-1:0] REG_MIRROR_ORIGIN = 3'd6;

	// Pixel formats in mode bits 1:0
	localparam logic [1:0] FMT_RGB565   = 2'd0;
	localparam logic [1:0] FMT_RGBA8888 = 2'd1;
	localparam logic [1:0] FMT_ARGB8888 = 2'd2;
	localparam logic [1:0] FMT_RGBA5551 = 2'd3;

	// Rotate flag position in mode
	localparam int MODE_ROT_BIT = 2;

	typedef struct packed {
		logic [2:0]         mode;
		logic [COORD_W-1:0] bitmap_rows;
		logic [CFG_W-1:0]   src_x_window;
		logic [CFG_W-1:0]   src_y_window;
		logic [SHIFT_W-1:0] x_shift;
		logic [SHIFT_W-1:0] y_shift;
		logic [COORD_W-1:0] mirror_origin;
	} cfg_t;

	typedef logic [CHAN_W-1:0] scale5_tab_t [32];
	typedef logic [CHAN_W-1:0] scale6_tab_t [64];

	// Build v*255/31 for every 5-bit code
	function automatic scale5_tab_t gen_scale5();
		scale5_tab_t tab;
		for (int i = 0; i < 32; i++) begin
			tab[i] = CHAN_W'((i * 255) / 31);
		end
		return tab;
	endfunction

	// Build v*255/63 for every 6-bit code
	function automatic scale6_tab_t gen_scale6();
		scale6_tab_t tab;
		for (int i = 0; i < 64; i++) begin
			tab[i] = CHAN_W'((i * 255) / 63);
		end
		return tab;
	endfunction

	localparam scale5_tab_t SCALE5 = gen_scale5();
	localparam scale6_tab_t SCALE6 = gen_scale6();

endpackage

// File: hw/rtl/fbwpm_pix_if.sv
// ----------------------------------------------------------------------------
// fbwpm_pix_if
// Input channel: one stored framebuffer pixel word with its position.
// ----------------------------------------------------------------------------
interface fbwpm_pix_if;
	logic                           valid;
	logic                           ready;
	logic [fbwpm_pkg::WORD_W-1:0]   pixel_word;
	logic [fbwpm_pkg::COORD_W-1:0]  column;
	logic [fbwpm_pkg::COORD_W-1:0]  stored_row;

	modport source (output valid, pixel_word, column, stored_row, input ready);
	modport sink (input valid, pixel_word, column, stored_row, output ready);
endinterface

// File: hw/rtl/fbwpm_rgb_if.sv
// ----------------------------------------------------------------------------
// fbwpm_rgb_if
// Output channel: one panel position with its 8-bit RGB color.
// ----------------------------------------------------------------------------
interface fbwpm_rgb_if;
	logic                           valid;
	logic                           ready;
	logic [fbwpm_pkg::COORD_W-1:0]  panel_x;
	logic [fbwpm_pkg::COORD_W-1:0]  panel_y;
	logic [fbwpm_pkg::CHAN_W-1:0]   r_level;
	logic [fbwpm_pkg::CHAN_W-1:0]   green;
	logic [fbwpm_pkg::CHAN_W-1:0]   blue;

	modport source (output valid, panel_x, panel_y, r_level, green, blue, input ready);
	modport sink (input valid, panel_x, panel_y, r_level, green, blue, output ready);
endinterface

// File: hw/rtl/fbwpm_cfg_regs.sv
// ----------------------------------------------------------------------------
// fbwpm_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module fbwpm_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fbwpm_pkg::IDX_W-1:0]    cfg_idx,
	input  logic [fbwpm_pkg::CFG_W-1:0]    cfg_wdata,
	output fbwpm_pkg::cfg_t                cfg
);

	fbwpm_pkg::cfg_t cfg_q;

	// Decode the index and store the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{
				mode:          3'd0,
				bitmap_rows:   fbwpm_pkg::COORD_W'(1),
				src_x_window:  '0,
				src_y_window:  '0,
				x_shift:       '0,
				y_shift:       '0,
				mirror_origin: '0
			};
		end else if (cfg_we) begin
			unique case (cfg_idx)
				fbwpm_pkg::REG_MODE:          cfg_q.mode          <= cfg_wdata[2:0];
				fbwpm_pkg::REG_BITMAP_ROWS:   cfg_q.bitmap_rows   <= cfg_wdata[11:0];
				fbwpm_pkg::REG_SRC_X_WINDOW:  cfg_q.src_x_window  <= cfg_wdata;
				fbwpm_pkg::REG_SRC_Y_WINDOW:  cfg_q.src_y_window  <= cfg_wdata;
				fbwpm_pkg::REG_X_SHIFT:       cfg_q.x_shift       <= cfg_wdata[12:0];
				fbwpm_pkg::REG_Y_SHIFT:       cfg_q.y_shift       <= cfg_wdata[12:0];
				fbwpm_pkg::REG_MIRROR_ORIGIN: cfg_q.mirror_origin <= cfg_wdata[11:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/fbwpm_coord_pipe.sv
// ----------------------------------------------------------------------------
// fbwpm_coord_pipe
// Four-stage position path: row flip, window test, shift, panel clip and
// mirror. Items that fall outside are dropped by clearing their valid bit.
// ----------------------------------------------------------------------------
module fbwpm_coord_pipe (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  logic                           in_valid,
	input  logic [fbwpm_pkg::COORD_W-1:0]  column,
	input  logic [fbwpm_pkg::COORD_W-1:0]  stored_row,
	input  fbwpm_pkg::cfg_t                cfg,
	output logic                           valid_out,
	output logic [fbwpm_pkg::COORD_W-1:0]  panel_x,
	output logic [fbwpm_pkg::COORD_W-1:0]  panel_y
);

	localparam int PW = fbwpm_pkg::POS_W;

	logic rot;

	// Stage 1: logical row and column window
	logic                           valid_s1;
	logic signed [PW-1:0]           lrow_s1;
	logic [fbwpm_pkg::COORD_W-1:0]  col_s1;
	logic signed [PW-1:0]           lrow_c;
	logic                           col_ok_c;

	// Stage 2: row window and shifted position
	logic                           valid_s2;
	logic signed [PW-1:0]           px_s2;
	logic signed [PW-1:0]           py_s2;
	logic                           row_ok_c;
	logic signed [PW-1:0]           px_c;
	logic signed [PW-1:0]           py_c;

	// Stage 3: panel clip and mirror
	logic                           valid_s3;
	logic signed [PW-1:0]           xsel_s3;
	logic [fbwpm_pkg::COORD_W-1:0]  py_s3;
	logic                           pos_ok_c;
	logic signed [PW-1:0]           xsel_c;

	// Stage 4: mirrored column check, output register
	logic                           valid_s4;
	logic [fbwpm_pkg::COORD_W-1:0]  px_s4;
	logic [fbwpm_pkg::COORD_W-1:0]  py_s4;
	logic                           x_ok_c;

	assign rot = cfg.mode[fbwpm_pkg::MODE_ROT_BIT];

	// Flip the row when rotating, test the column window
	always_comb begin
		if (rot) begin
			lrow_c = $signed(PW'(cfg.bitmap_rows)) - $signed(PW'(1))
				- $signed(PW'(stored_row));
		end else begin
			lrow_c = $signed(PW'(stored_row));
		end
		col_ok_c = (16'(column) >= cfg.src_x_window[15:0])
			&& (16'(column) < cfg.src_x_window[31:16]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid && col_ok_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lrow_s1 <= lrow_c;
			col_s1  <= column;
		end
	end

	// Test the row against bitmap and window, apply the shifts
	always_comb begin
		row_ok_c = !lrow_s1[PW-1]
			&& (lrow_s1[fbwpm_pkg::COORD_W-1:0] < cfg.bitmap_rows)
			&& (16'(lrow_s1[fbwpm_pkg::COORD_W-1:0]) >= cfg.src_y_window[15:0])
			&& (16'(lrow_s1[fbwpm_pkg::COORD_W-1:0]) < cfg.src_y_window[31:16]);
		px_c = $signed(PW'(col_s1)) + PW'($signed(cfg.x_shift));
		py_c = lrow_s1 + PW'($signed(cfg.y_shift));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && row_ok_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s2 <= px_c;
			py_s2 <= py_c;
		end
	end

	// Clip to the panel and pick the mirrored column when rotating
	always_comb begin
		pos_ok_c = !px_s2[PW-1] && (px_s2 < $signed(PW'(fbwpm_pkg::PANEL_WIDTH)))
			&& !py_s2[PW-1] && (py_s2 < $signed(PW'(fbwpm_pkg::PANEL_HEIGHT)));
		if (rot) begin
			xsel_c = $signed(PW'(cfg.mirror_origin)) - px_s2;
		end else begin
			xsel_c = px_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2 && pos_ok_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xsel_s3 <= xsel_c;
			py_s3   <= py_s2[fbwpm_pkg::COORD_W-1:0];
		end
	end

	// Drop a mirrored column that left the panel
	assign x_ok_c = !xsel_s3[PW-1] && (xsel_s3 < $signed(PW'(fbwpm_pkg::PANEL_WIDTH)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3 && x_ok_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s4 <= xsel_s3[fbwpm_pkg::COORD_W-1:0];
			py_s4 <= py_s3;
		end
	end

	assign valid_out = valid_s4;
	assign panel_x   = px_s4;
	assign panel_y   = py_s4;

endmodule

// File: hw/rtl/fbwpm_color_pipe.sv
// ----------------------------------------------------------------------------
// fbwpm_color_pipe
// Color path in step with the position path: carries the pixel word, unpacks
// it to 8-bit RGB in the third stage and holds it in the output register.
// ----------------------------------------------------------------------------
module fbwpm_color_pipe (
	input  logic                           clk,
	input  logic                           adv,
	input  logic [1:0]                     fmt,
	input  logic [fbwpm_pkg::WORD_W-1:0]   pixel_word,
	output logic [fbwpm_pkg::CHAN_W-1:0]   r_level,
	output logic [fbwpm_pkg::CHAN_W-1:0]   green,
	output logic [fbwpm_pkg::CHAN_W-1:0]   blue
);

	localparam int CW = fbwpm_pkg::CHAN_W;

	logic [fbwpm_pkg::WORD_W-1:0] word_s1;
	logic [fbwpm_pkg::WORD_W-1:0] word_s2;
	logic [CW-1:0]                r_s3, g_s3, b_s3;
	logic [CW-1:0]                r_s4, g_s4, b_s4;
	logic [CW-1:0]                r_c, g_c, b_c;

	// Carry the word alongside the position checks
	always_ff @(posedge clk) begin
		if (adv) begin
			word_s1 <= pixel_word;
			word_s2 <= word_s1;
		end
	end

	// Unpack by format, widening 5- and 6-bit channels through the tables
	always_comb begin
		unique case (fmt)
			fbwpm_pkg::FMT_RGB565: begin
				r_c = fbwpm_pkg::SCALE5[word_s2[15:11]];
				g_c = fbwpm_pkg::SCALE6[word_s2[10:5]];
				b_c = fbwpm_pkg::SCALE5[word_s2[4:0]];
			end
			fbwpm_pkg::FMT_RGBA8888: begin
				r_c = word_s2[31:24];
				g_c = word_s2[23:16];
				b_c = word_s2[15:8];
			end
			fbwpm_pkg::FMT_ARGB8888: begin
				r_c = word_s2[23:16];
				g_c = word_s2[15:8];
				b_c = word_s2[7:0];
			end
			default: begin
				r_c = fbwpm_pkg::SCALE5[word_s2[15:11]];
				g_c = fbwpm_pkg::SCALE5[word_s2[10:6]];
				b_c = fbwpm_pkg::SCALE5[word_s2[5:1]];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s3 <= r_c;
			g_s3 <= g_c;
			b_s3 <= b_c;
			r_s4 <= r_s3;
			g_s4 <= g_s3;
			b_s4 <= b_s3;
		end
	end

	assign r_level = r_s4;
	assign green   = g_s4;
	assign blue    = b_s4;

endmodule

// File: hw/rtl/framebuffer_window_pixel_mapper_core.sv
// ----------------------------------------------------------------------------
// framebuffer_window_pixel_mapper_core
// Four register stages; a result becomes valid once its input item reaches
// the output register, and it is held there until it is taken.
// Throughput: one item per cycle unless the output stalls; the four pipeline
// stages advance together whenever the output register is empty or being taken.
// Dropped pixels leave a bubble and produce no result.
// Reset: pipeline empty, mode 0, bitmap_rows 1, all other registers 0.
// ----------------------------------------------------------------------------
module framebuffer_window_pixel_mapper_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fbwpm_pkg::IDX_W-1:0]    cfg_idx,
	input  logic [fbwpm_pkg::CFG_W-1:0]    cfg_wdata,
	fbwpm_pix_if.sink                      pix,
	fbwpm_rgb_if.source                    rgb
);

	fbwpm_pkg::cfg_t cfg;
	logic            adv;
	logic            valid_out;

	fbwpm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Advance all stages while the output register is free or being taken
	assign adv       = !valid_out || rgb.ready;
	assign pix.ready = adv;

	fbwpm_coord_pipe u_coord (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (pix.valid),
		.column     (pix.column),
		.stored_row (pix.stored_row),
		.cfg        (cfg),
		.valid_out  (valid_out),
		.panel_x    (rgb.panel_x),
		.panel_y    (rgb.panel_y)
	);

	fbwpm_color_pipe u_color (
		.clk        (clk),
		.adv        (adv),
		.fmt        (cfg.mode[1:0]),
		.pixel_word (pix.pixel_word),
		.r_level    (rgb.r_level),
		.green      (rgb.green),
		.blue       (rgb.blue)
	);

	assign rgb.valid = valid_out;

endmodule
